// ----- rtl/cor_pkg.sv -----
// cor_pkg: shared constants, command record and state type for the circle octant rasterizer
// no dependencies; imported by every rtl module of the block
package cor_pkg;

   localparam int ADDR_BITS    = 24;
   localparam int MAX_DIAMETER = 120;
   localparam int COORD_BITS   = 12;

   localparam int DIAM_BITS    = 7;
   localparam int WIDTH_BITS   = 13;
   localparam int COLOR_BITS   = 32;
   localparam int NUM_OCT      = 8;
   localparam int RADIUS_BITS  = $clog2(MAX_DIAMETER / 2 + 1);
   localparam int ERR_BITS     = 2 * RADIUS_BITS + 3;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);

   typedef struct packed {
      logic [COORD_BITS-1:0]  center_x;
      logic [ADDR_BITS-1:0]   row_base;
      logic [ADDR_BITS-1:0]   radius_offset;
      logic [RADIUS_BITS-1:0] radius;
      logic [COLOR_BITS-1:0]  color;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

// ----- rtl/cor_front.sv -----
// cor_front: accepts a circle request, saturates the diameter and precomputes row offsets
// depends on cor_pkg
module cor_front
   import cor_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [COORD_BITS-1:0]  req_center_x,
   input  logic [COORD_BITS-1:0]  req_center_y,
   input  logic [DIAM_BITS-1:0]   req_diameter,
   input  logic [COLOR_BITS-1:0]  req_pen_color,
   input  logic [WIDTH_BITS-1:0]  image_width,
   output logic                   cmd_push,
   output cmd_type                cmd_data,
   input  logic                   cmd_full
);

   logic                                  valid_ff, valid_in;
   cmd_type                               cmd_ff, cmd_in;
   logic [DIAM_BITS-1:0]                  diam_sat;
   logic [RADIUS_BITS-1:0]                radius;
   logic [COORD_BITS+WIDTH_BITS-1:0]      row_prod;
   logic [RADIUS_BITS+WIDTH_BITS-1:0]     rad_prod;
   logic                                  accept;

   assign req_full = valid_ff && cmd_full;
   assign accept   = req_push && !req_full;
   assign cmd_push = valid_ff && !cmd_full;
   assign cmd_data = cmd_ff;

   always_comb begin
      if (req_diameter > DIAM_BITS'(MAX_DIAMETER)) begin
         diam_sat = DIAM_BITS'(MAX_DIAMETER);
      end else begin
         diam_sat = req_diameter;
      end
      radius   = RADIUS_BITS'(diam_sat >> 1);
      row_prod = req_center_y * image_width;
      rad_prod = radius * image_width;

      cmd_in.center_x      = req_center_x;
      cmd_in.row_base      = ADDR_BITS'(row_prod);
      cmd_in.radius_offset = ADDR_BITS'(rad_prod);
      cmd_in.radius        = radius;
      cmd_in.color         = req_pen_color;

      if (accept) begin
         valid_in = 1'b1;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ----- rtl/cor_cmd_fifo.sv -----
// cor_cmd_fifo: short command queue between front and back
// depends on cor_pkg
module cor_cmd_fifo
   import cor_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                  entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign full     = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                     : wr_ptr_ff + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                     : rd_ptr_ff + FIFO_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/cor_back.sv -----
// cor_back: midpoint circle stepper, one octant set per cycle while results are popped, with the result register
// depends on cor_pkg
module cor_back
   import cor_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WIDTH_BITS-1:0] image_width,
   input  cmd_type               cmd_data,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [ADDR_BITS-1:0]  rsp_addr [NUM_OCT],
   output logic [COLOR_BITS-1:0] rsp_write_color,
   output logic                  rsp_last
);

   back_state_type               state_ff, state_in;
   logic [RADIUS_BITS-1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic [ADDR_BITS-1:0]         dxw_ff, dxw_in, dyw_ff, dyw_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic [COORD_BITS-1:0]        cx_ff, cx_in;
   logic [ADDR_BITS-1:0]         yw_ff, yw_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         out_valid_ff, out_valid_in;
   logic [ADDR_BITS-1:0]         out_addr_ff [NUM_OCT];
   logic [ADDR_BITS-1:0]         addr_in [NUM_OCT];
   logic [COLOR_BITS-1:0]        out_color_ff;
   logic                         out_last_ff;
   logic                         step;
   logic                         done;
   logic [ADDR_BITS-1:0]         row_mdx, row_mdy, row_pdx, row_pdy;
   logic [ADDR_BITS-1:0]         col_pdx, col_mdx, col_pdy, col_mdy;
   logic [ADDR_BITS-1:0]         cx_ext, dx_ext, dy_ext, w_ext;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_addr        = out_addr_ff;
   assign rsp_write_color = out_color_ff;
   assign rsp_last        = out_last_ff;

   assign step = (state_ff == BACK_RUN) && (!out_valid_ff || rsp_pop);
   assign done = (dx_ff == dy_ff);

   // octant addresses from the running row offsets
   always_comb begin
      cx_ext  = ADDR_BITS'(cx_ff);
      dx_ext  = ADDR_BITS'(dx_ff);
      dy_ext  = ADDR_BITS'(dy_ff);
      row_mdx = yw_ff - dxw_ff;
      row_mdy = yw_ff - dyw_ff;
      row_pdx = yw_ff + dxw_ff;
      row_pdy = yw_ff + dyw_ff;
      col_pdx = cx_ext + dx_ext;
      col_mdx = cx_ext - dx_ext;
      col_pdy = cx_ext + dy_ext;
      col_mdy = cx_ext - dy_ext;
      addr_in[0] = row_mdx + col_pdy;
      addr_in[1] = row_mdy + col_pdx;
      addr_in[2] = row_mdy + col_mdx;
      addr_in[3] = row_mdx + col_mdy;
      addr_in[4] = row_pdx + col_mdy;
      addr_in[5] = row_pdy + col_pdx;
      addr_in[6] = row_pdy + col_mdx;
      addr_in[7] = row_pdx + col_pdy;
   end

   always_comb begin
      w_ext    = ADDR_BITS'(image_width);
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dxw_in   = dxw_ff;
      dyw_in   = dyw_ff;
      err_in   = err_ff;
      cx_in    = cx_ff;
      yw_in    = yw_ff;
      color_in = color_ff;
      cmd_pop  = 1'b0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               state_in = BACK_RUN;
               dx_in    = '0;
               dy_in    = cmd_data.radius;
               dxw_in   = '0;
               dyw_in   = cmd_data.radius_offset;
               err_in   = '0;
               cx_in    = cmd_data.center_x;
               yw_in    = cmd_data.row_base;
               color_in = cmd_data.color;
            end
         end
         BACK_RUN: begin
            if (step) begin
               if (done) begin
                  state_in = BACK_IDLE;
               end else if (!err_ff[ERR_BITS-1]) begin
                  dy_in  = dy_ff - RADIUS_BITS'(1);
                  dyw_in = dyw_ff - w_ext;
                  err_in = err_ff - ERR_BITS'({dy_ff, 1'b0}) + ERR_BITS'(1);
               end else begin
                  dx_in  = dx_ff + RADIUS_BITS'(1);
                  dxw_in = dxw_ff + w_ext;
                  err_in = err_ff + ERR_BITS'({dx_ff, 1'b1});
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dxw_ff   <= dxw_in;
      dyw_ff   <= dyw_in;
      err_ff   <= err_in;
      cx_ff    <= cx_in;
      yw_ff    <= yw_in;
      color_ff <= color_in;
      if (step) begin
         out_addr_ff  <= addr_in;
         out_color_ff <= color_ff;
         out_last_ff  <= done;
      end
   end

endmodule

// ----- rtl/circle_octant_rasterizer_top.sv -----
// circle_octant_rasterizer_top: a taken request passes the front register, the command queue
// and the stepper's load state to the result register on the rsp ports; a circle of radius r
// gives r+1 results, one per cycle while rsp_pop holds; the stepper takes no new command until
// its last step, and the front keeps taking requests meanwhile until the queue fills
// synchronous reset empties the queues, idles the stepper and sets image width to 640
// depends on cor_pkg, cor_front, cor_cmd_fifo, cor_back
module circle_octant_rasterizer_top
   import cor_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [WIDTH_BITS-1:0] csr_write_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [COORD_BITS-1:0] req_center_x,
   input  logic [COORD_BITS-1:0] req_center_y,
   input  logic [DIAM_BITS-1:0]  req_diameter,
   input  logic [COLOR_BITS-1:0] req_pen_color,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct0,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct1,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct2,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct3,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct4,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct5,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct6,
   output logic [ADDR_BITS-1:0]  rsp_addr_oct7,
   output logic [COLOR_BITS-1:0] rsp_write_color,
   output logic                  rsp_last
);

   logic [WIDTH_BITS-1:0] image_width_ff;
   cmd_type               front_cmd, fifo_cmd;
   logic                  front_push, fifo_full, fifo_empty, fifo_pop;
   logic [ADDR_BITS-1:0]  addr [NUM_OCT];

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= WIDTH_RESET;
      end else if (csr_write_en) begin
         image_width_ff <= csr_write_data;
      end
   end

   cor_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_diameter  (req_diameter),
      .req_pen_color (req_pen_color),
      .image_width   (image_width_ff),
      .cmd_push      (front_push),
      .cmd_data      (front_cmd),
      .cmd_full      (fifo_full)
   );

   cor_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_cmd),
      .empty     (fifo_empty)
   );

   cor_back u_back (
      .clock           (clock),
      .reset           (reset),
      .image_width     (image_width_ff),
      .cmd_data        (fifo_cmd),
      .cmd_empty       (fifo_empty),
      .cmd_pop         (fifo_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_addr        (addr),
      .rsp_write_color (rsp_write_color),
      .rsp_last        (rsp_last)
   );

   assign rsp_addr_oct0 = addr[0];
   assign rsp_addr_oct1 = addr[1];
   assign rsp_addr_oct2 = addr[2];
   assign rsp_addr_oct3 = addr[3];
   assign rsp_addr_oct4 = addr[4];
   assign rsp_addr_oct5 = addr[5];
   assign rsp_addr_oct6 = addr[6];
   assign rsp_addr_oct7 = addr[7];

endmodule

// ----- rtl/cor_checker.sv -----
// cor_checker: port-level assertions for the circle octant rasterizer, bound to the top level
// depends on cor_pkg and circle_octant_rasterizer_top
module cor_checker
   import cor_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [ADDR_BITS-1:0]  rsp_addr_oct0,
   input logic [ADDR_BITS-1:0]  rsp_addr_oct1,
   input logic [ADDR_BITS-1:0]  rsp_addr_oct4,
   input logic [ADDR_BITS-1:0]  rsp_addr_oct5,
   input logic [ADDR_BITS-1:0]  rsp_addr_oct6,
   input logic [ADDR_BITS-1:0]  rsp_addr_oct7,
   input logic [COLOR_BITS-1:0] rsp_write_color,
   input logic                  rsp_last
);

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // on the last step dx equals dy, so mirrored octants land on the same pixel
   a_last_mirror: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |->
         (rsp_addr_oct0 == rsp_addr_oct1) && (rsp_addr_oct4 == rsp_addr_oct6) &&
         (rsp_addr_oct7 == rsp_addr_oct5))
      else $error("last request octants do not coincide");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("request dropped without pop");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         $stable(rsp_addr_oct0) && $stable(rsp_write_color) && $stable(rsp_last))
      else $error("stalled request changed");

endmodule

bind circle_octant_rasterizer_top cor_checker u_cor_checker (.*);

// ----- tb/sv/circle_octant_rasterizer_top_tb.sv -----
// circle_octant_rasterizer_top_tb: self-checking bench for the circle octant rasterizer
// predicts every octant address row of each circle and checks it against the rsp queue
// depends on cor_pkg and circle_octant_rasterizer_top
module circle_octant_rasterizer_top_tb;
   import cor_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [NUM_OCT-1:0][ADDR_BITS-1:0] addr;
      logic [COLOR_BITS-1:0]             color;
      logic                              last;
   } octant_row_type;

   class circle_tracker;
      octant_row_type        pending_rows[$];
      logic [WIDTH_BITS-1:0] row_pitch;
      int                    errors;

      function new();
         row_pitch = WIDTH_RESET;
         errors = 0;
      endfunction

      function void set_pitch(input logic [WIDTH_BITS-1:0] pitch);
         row_pitch = pitch;
      endfunction

      function logic [ADDR_BITS-1:0] pixel_addr(input bit [63:0] row, input bit [63:0] col);
         return ADDR_BITS'(row * row_pitch + col);
      endfunction

      // walk the midpoint circle and queue one row of eight addresses per step
      function void note_request(input logic [COORD_BITS-1:0] cx,
                                 input logic [COORD_BITS-1:0] cy,
                                 input logic [DIAM_BITS-1:0]  diam,
                                 input logic [COLOR_BITS-1:0] color);
         int unsigned    d;
         int unsigned    r;
         int unsigned    dx;
         int unsigned    dy;
         bit [63:0]      x;
         bit [63:0]      y;
         octant_row_type p;
         d = (diam > MAX_DIAMETER) ? MAX_DIAMETER : diam;
         r = d / 2;
         dx = 0;
         dy = r;
         x = cx;
         y = cy;
         do begin
            p.addr[0] = pixel_addr(y - dx, x + dy);
            p.addr[1] = pixel_addr(y - dy, x + dx);
            p.addr[2] = pixel_addr(y - dy, x - dx);
            p.addr[3] = pixel_addr(y - dx, x - dy);
            p.addr[4] = pixel_addr(y + dx, x - dy);
            p.addr[5] = pixel_addr(y + dy, x + dx);
            p.addr[6] = pixel_addr(y + dy, x - dx);
            p.addr[7] = pixel_addr(y + dx, x + dy);
            p.color = color;
            p.last = (dx == dy);
            pending_rows.push_back(p);
            if (dx * dx + dy * dy >= r * r) begin
               dy--;
            end else begin
               dx++;
            end
         end while (!p.last);
      endfunction

      task report_mismatch(input string field, input logic [63:0] got,
                           input logic [63:0] want);
         errors++;
         if (errors <= 50) begin
            $display("%0t mismatch %s: got %h expected %h", $time, field, got, want);
         end
      endtask

      task check_row(input octant_row_type got);
         octant_row_type want;
         if (pending_rows.size() == 0) begin
            report_mismatch("result with nothing pending", 64'(got.color), 64'd0);
            return;
         end
         want = pending_rows.pop_front();
         for (int i = 0; i < NUM_OCT; i++) begin
            if (got.addr[i] !== want.addr[i]) begin
               report_mismatch($sformatf("addr_oct%0d", i),
                               64'(got.addr[i]), 64'(want.addr[i]));
            end
         end
         if (got.color !== want.color) begin
            report_mismatch("write_color", 64'(got.color), 64'(want.color));
         end
         if (got.last !== want.last) begin
            report_mismatch("last", 64'(got.last), 64'(want.last));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [WIDTH_BITS-1:0] csr_write_data = '0;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [COORD_BITS-1:0] req_center_x = '0;
   logic [COORD_BITS-1:0] req_center_y = '0;
   logic [DIAM_BITS-1:0]  req_diameter = '0;
   logic [COLOR_BITS-1:0] req_pen_color = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [ADDR_BITS-1:0]  rsp_addr_oct0;
   logic [ADDR_BITS-1:0]  rsp_addr_oct1;
   logic [ADDR_BITS-1:0]  rsp_addr_oct2;
   logic [ADDR_BITS-1:0]  rsp_addr_oct3;
   logic [ADDR_BITS-1:0]  rsp_addr_oct4;
   logic [ADDR_BITS-1:0]  rsp_addr_oct5;
   logic [ADDR_BITS-1:0]  rsp_addr_oct6;
   logic [ADDR_BITS-1:0]  rsp_addr_oct7;
   logic [COLOR_BITS-1:0] rsp_write_color;
   logic                  rsp_last;

   circle_tracker tracker;
   bit            push_steady = 1'b0;
   bit            pop_steady = 1'b0;
   int            quiet_cycles = 0;

   circle_octant_rasterizer_top uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_diameter    (req_diameter),
      .req_pen_color   (req_pen_color),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_addr_oct0   (rsp_addr_oct0),
      .rsp_addr_oct1   (rsp_addr_oct1),
      .rsp_addr_oct2   (rsp_addr_oct2),
      .rsp_addr_oct3   (rsp_addr_oct3),
      .rsp_addr_oct4   (rsp_addr_oct4),
      .rsp_addr_oct5   (rsp_addr_oct5),
      .rsp_addr_oct6   (rsp_addr_oct6),
      .rsp_addr_oct7   (rsp_addr_oct7),
      .rsp_write_color (rsp_write_color),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      endcase
   endfunction

   // mostly small circles, a few up to and past the diameter limit
   function automatic logic [DIAM_BITS-1:0] rand_diameter();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return DIAM_BITS'($urandom_range(0, 24));
      if (pick < 9) return DIAM_BITS'($urandom_range(0, (1 << DIAM_BITS) - 1));
      return DIAM_BITS'($urandom_range(MAX_DIAMETER - 8, (1 << DIAM_BITS) - 1));
   endfunction

   function automatic logic [COLOR_BITS-1:0] rand_color();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return COLOR_BITS'($urandom);
      endcase
   endfunction

   task automatic send_circle(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                              input logic [DIAM_BITS-1:0] diam,
                              input logic [COLOR_BITS-1:0] color);
      int gap;
      req_center_x <= cx;
      req_center_y <= cy;
      req_diameter <= diam;
      req_pen_color <= color;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      gap = push_steady ? 0 : idle_span();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (tracker.pending_rows.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_pitch(input logic [WIDTH_BITS-1:0] pitch);
      csr_write_data <= pitch;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.set_pitch(pitch);
   endtask

   // request and result monitors
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         tracker.note_request(req_center_x, req_center_y, req_diameter, req_pen_color);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         tracker.check_row({rsp_addr_oct7, rsp_addr_oct6, rsp_addr_oct5, rsp_addr_oct4,
                            rsp_addr_oct3, rsp_addr_oct2, rsp_addr_oct1, rsp_addr_oct0,
                            rsp_write_color, rsp_last});
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** circle_octant_rasterizer_top: FAILED **");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
         end else begin
            rsp_pop <= 1'b1;
            if (!pop_steady && $urandom_range(0, 2) == 0) hold = idle_span();
         end
      end
   end

   initial begin
      logic [WIDTH_BITS-1:0] pitches[6];
      tracker = new();
      pitches[0] = WIDTH_BITS'(1);
      pitches[1] = WIDTH_BITS'(4096);
      pitches[2] = '0;
      pitches[3] = '1;
      pitches[4] = WIDTH_BITS'($urandom_range(1, 4096));
      pitches[5] = WIDTH_BITS'($urandom_range(0, (1 << WIDTH_BITS) - 1));
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset pitch: zero radius, saturation, edge wrap, color extremes
      send_circle(12'd0, 12'd0, 7'd0, 32'h0000_0000);
      send_circle(12'd4095, 12'd4095, 7'd1, 32'hFFFF_FFFF);
      send_circle(12'd0, 12'd0, 7'd2, 32'h1234_5678);
      send_circle(12'd4095, 12'd0, 7'd3, 32'h8000_0001);
      send_circle(12'd0, 12'd4095, 7'd10, 32'hA5A5_5A5A);
      send_circle(12'd2048, 12'd2048, 7'd120, 32'h0F0F_F0F0);
      send_circle(12'd100, 12'd100, 7'd127, 32'hDEAD_BEEF);
      send_circle(12'd4095, 12'd4095, 7'd121, 32'h7FFF_FFFF);
      send_circle(12'd5, 12'd7, 7'd60, 32'hFFFF_0000);
      send_circle(12'd0, 12'd0, 7'd119, 32'h0000_FFFF);
      send_circle(12'd30, 12'd40, 7'd4, 32'h5555_AAAA);
      send_circle(12'd4095, 12'd4095, 7'd5, 32'hAAAA_5555);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         write_pitch(pitches[phase]);
         push_steady = ($urandom_range(0, 3) == 0);
         pop_steady = ($urandom_range(0, 3) == 0);
         repeat (16) begin
            send_circle(rand_coord(), rand_coord(), rand_diameter(), rand_color());
         end
      end

      push_steady = 1'b0;
      pop_steady = 1'b0;
      drain();
      if (tracker.errors == 0) begin
         $display("** circle_octant_rasterizer_top: PASSED **");
      end else begin
         $display("** circle_octant_rasterizer_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cor_pkg.sv
rtl/cor_front.sv
rtl/cor_cmd_fifo.sv
rtl/cor_back.sv
rtl/circle_octant_rasterizer_top.sv
rtl/cor_checker.sv
tb/sv/circle_octant_rasterizer_top_tb.sv
